// ===== hdl/ace3_pkg.sv =====
// Shared widths and constants for the 3x3 adaptive contrast enhancement core.
// No dependencies.
package ace3_pkg;

	localparam int PIX_W      = 8;
	localparam int NUM_PIX    = 9;
	localparam int IN_W       = PIX_W * NUM_PIX;
	localparam int SUM_W      = 12;  // window sum, up to 2295
	localparam int SQ_W       = 20;  // sum of squares, up to 585225
	localparam int VAR_W      = 24;  // 9Q - S^2, up to 1300500, kept even
	localparam int DIFF_W     = 11;  // |9c - S|, up to 2040
	localparam int GAIN_W     = 8;
	localparam int NUM_W      = DIFF_W + GAIN_W;
	localparam int CENTER_IDX = 4;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd3;
	localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;

endpackage

// ===== hdl/adaptive_contrast_enhance_3x3_core.sv =====
// Adaptive contrast enhancement of one 3x3 window by local standard deviation.
// Depends on ace3_pkg.
//
// Pipeline: two front stages, one square-root bit per stage, one quotient bit per stage,
// one output register. Throughput: one window per cycle; a stall on the output freezes
// every stage. Reset clears the valid bits and loads the gain with 3.
module adaptive_contrast_enhance_3x3_core #(
	parameter int FRAC_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// tdata: pix_top_left, pix_top, pix_top_right, pix_left, pix_center,
	//        pix_right, pix_bottom_left, pix_bottom, pix_bottom_right (8 bits each)
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ace3_pkg::IN_W-1:0] s_tdata,
	// tdata: pixel_out (8 bits); tuser: clipped
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,
	output logic                      m_tuser,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ace3_pkg::GAIN_W-1:0] cfg_data
);
	import ace3_pkg::*;

	localparam int RAD_W  = VAR_W + 2 * FRAC_BITS;
	localparam int RT_W   = RAD_W / 2;
	localparam int QW     = NUM_W + 2 * FRAC_BITS;
	localparam int MEAN_W = PIX_W + FRAC_BITS;
	localparam int XW     = QW + 2;
	localparam int MN     = SUM_W + FRAC_BITS;
	localparam int MK     = MN + 4;
	localparam logic [63:0] MREC = ((64'd1 << MK) + 64'd8) / 64'd9;

	typedef struct packed {
		logic [NUM_W-1:0]  num;
		logic              neg;
		logic              flat;
		logic [MEAN_W-1:0] mean;
	} side_t;

	logic en;
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	logic [GAIN_W-1:0] gain_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	// Stage 1: window sum and sum of squares
	logic [SUM_W-1:0] sum_c;
	logic [SQ_W-1:0]  sq_c;
	always_comb begin
		logic [PIX_W-1:0] p;
		sum_c = '0;
		sq_c  = '0;
		for (int i = 0; i < NUM_PIX; i++) begin
			p     = s_tdata[i*PIX_W +: PIX_W];
			sum_c = sum_c + SUM_W'(p);
			sq_c  = sq_c + SQ_W'(p * p);
		end
	end

	logic             vld_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [SQ_W-1:0]  sq_s1;
	logic [PIX_W-1:0] ctr_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_c;
			sq_s1  <= sq_c;
			ctr_s1 <= s_tdata[CENTER_IDX*PIX_W +: PIX_W];
		end
	end

	// Stage 2: variance term, weighted numerator, mean by reciprocal
	logic [SUM_W+3:0]    ctr9_c;
	logic [DIFF_W-1:0]   diff_c;
	logic                neg_c;
	logic [VAR_W-1:0]    var_c;
	logic [MN+MK:0]      mprod_c;
	always_comb begin
		ctr9_c  = (SUM_W + 4)'(ctr_s1) * 16'd9;
		neg_c   = ctr9_c < (SUM_W + 4)'(sum_s1);
		diff_c  = neg_c ? DIFF_W'((SUM_W + 4)'(sum_s1) - ctr9_c)
		                : DIFF_W'(ctr9_c - (SUM_W + 4)'(sum_s1));
		var_c   = VAR_W'((VAR_W)'(sq_s1) * 24'd9 - (VAR_W)'(sum_s1) * (VAR_W)'(sum_s1));
		mprod_c = (MN + MK + 1)'({sum_s1, {FRAC_BITS{1'b0}}}) * MREC[MK:0];
	end

	logic             vld_s2;
	logic [RAD_W-1:0] rad_s2;
	side_t            side_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2       <= {var_c, {(2 * FRAC_BITS){1'b0}}};
			side_s2.num  <= NUM_W'(diff_c * gain_q);
			side_s2.neg  <= neg_c;
			side_s2.flat <= (var_c == '0);
			side_s2.mean <= mprod_c[MK +: MEAN_W];
		end
	end

	// Square root, one result bit per stage
	logic             sq_vld_sn  [RT_W];
	logic [RAD_W-1:0] sq_rad_sn  [RT_W];
	logic [RT_W:0]    sq_rem_sn  [RT_W];
	logic [RT_W-1:0]  sq_root_sn [RT_W];
	side_t            sq_side_sn [RT_W];

	for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
		logic             v_in;
		logic [RAD_W-1:0] rad_in;
		logic [RT_W:0]    rem_in;
		logic [RT_W-1:0]  root_in;
		side_t            side_in;
		logic [RT_W+2:0]  cand;
		logic [RT_W+2:0]  trial;
		logic             take;
		if (k == 0) begin : g_first
			assign v_in    = vld_s2;
			assign rad_in  = rad_s2;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = side_s2;
		end else begin : g_next
			assign v_in    = sq_vld_sn[k-1];
			assign rad_in  = sq_rad_sn[k-1];
			assign rem_in  = sq_rem_sn[k-1];
			assign root_in = sq_root_sn[k-1];
			assign side_in = sq_side_sn[k-1];
		end
		assign cand  = {rem_in, rad_in[RAD_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign take  = cand >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_sn[k] <= 1'b0;
			end else if (en) begin
				sq_vld_sn[k] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_sn[k]  <= {rad_in[RAD_W-3:0], 2'b00};
				sq_rem_sn[k]  <= take ? (RT_W + 1)'(cand - trial) : cand[RT_W:0];
				sq_root_sn[k] <= {root_in[RT_W-2:0], take};
				sq_side_sn[k] <= side_in;
			end
		end
	end

	// Restoring divide, one quotient bit per stage
	logic            dv_vld_sn  [QW];
	logic [RT_W-1:0] dv_den_sn  [QW];
	logic [RT_W-1:0] dv_rem_sn  [QW];
	logic [QW-1:0]   dv_quo_sn  [QW];
	side_t           dv_side_sn [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic            v_in;
		logic [RT_W-1:0] den_in;
		logic [RT_W-1:0] rem_in;
		logic [QW-1:0]   quo_in;
		side_t           side_in;
		logic [RT_W:0]   t;
		logic            take;
		if (j == 0) begin : g_first
			assign v_in    = sq_vld_sn[RT_W-1];
			assign den_in  = sq_root_sn[RT_W-1];
			assign rem_in  = '0;
			assign quo_in  = {sq_side_sn[RT_W-1].num, {(2 * FRAC_BITS){1'b0}}};
			assign side_in = sq_side_sn[RT_W-1];
		end else begin : g_next
			assign v_in    = dv_vld_sn[j-1];
			assign den_in  = dv_den_sn[j-1];
			assign rem_in  = dv_rem_sn[j-1];
			assign quo_in  = dv_quo_sn[j-1];
			assign side_in = dv_side_sn[j-1];
		end
		assign t    = {rem_in, quo_in[QW-1]};
		assign take = t >= {1'b0, den_in};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_sn[j] <= 1'b0;
			end else if (en) begin
				dv_vld_sn[j] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_sn[j]  <= den_in;
				dv_rem_sn[j]  <= take ? RT_W'(t - {1'b0, den_in}) : t[RT_W-1:0];
				dv_quo_sn[j]  <= {quo_in[QW-2:0], take};
				dv_side_sn[j] <= side_in;
			end
		end
	end

	// Output: add mean back, round half up, saturate
	side_t                side_f;
	logic signed [XW-1:0] term_c;
	logic signed [XW-1:0] x_c;
	logic [XW-1:0]        y_c;
	logic [PIX_W-1:0]     pix_c;
	logic                 clip_c;
	always_comb begin
		side_f = dv_side_sn[QW-1];
		term_c = side_f.flat ? '0 : $signed({2'b00, dv_quo_sn[QW-1]});
		x_c    = $signed(XW'(side_f.mean)) + $signed(XW'(1) <<< (FRAC_BITS - 1));
		x_c    = side_f.neg ? x_c - term_c : x_c + term_c;
		y_c    = XW'(x_c >>> FRAC_BITS);
		if (x_c < 0) begin
			pix_c  = '0;
			clip_c = 1'b1;
		end else if (y_c > XW'(PIX_MAX)) begin
			pix_c  = PIX_MAX;
			clip_c = 1'b1;
		end else begin
			pix_c  = y_c[PIX_W-1:0];
			clip_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_vld_sn[QW-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= pix_c;
			m_tuser <= clip_c;
		end
	end

endmodule

// ===== tb/tb_adaptive_contrast_enhance_3x3_core.sv =====
// Self-checking testbench for adaptive_contrast_enhance_3x3_core: directed windows,
// then random windows over several gain settings, checked against a local predictor.
// Depends on ace3_pkg and the core.
`timescale 1ns / 100ps

module tb_adaptive_contrast_enhance_3x3_core;
	import ace3_pkg::*;

	localparam int FRAC     = 8;
	localparam int LATENCY  = 58;
	localparam int MAX_CYC  = 300000;
	localparam int IDLE_PCT = 18;

	typedef logic [PIX_W-1:0] window_t [NUM_PIX];

	typedef struct {
		logic [7:0] pixel_out;
		logic       clipped;
	} enhanced_t;

	typedef struct {
		logic [GAIN_W-1:0] gain;
		window_t           win;
		bit                known;
		enhanced_t         res;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;
	logic                m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [GAIN_W-1:0]   cfg_data = '0;

	logic [GAIN_W-1:0]   gain_now = GAIN_RESET;
	enhanced_t           pending_pixels[$];
	int                  err_count = 0;
	int                  cycle_count = 0;
	bit                  tx_steady = 1'b0;
	bit                  rx_steady = 1'b0;

	adaptive_contrast_enhance_3x3_core #(.FRAC_BITS(FRAC)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic enhanced_t enhance_window(window_t w, logic [GAIN_W-1:0] g);
		longint unsigned sum, sq, var9, root, num, term, mean_fx;
		longint signed   x;
		bit              neg;
		enhanced_t       r;
		sum = 0;
		sq = 0;
		term = 0;
		for (int i = 0; i < NUM_PIX; i++) begin
			sum += w[i];
			sq += w[i] * w[i];
		end
		var9 = 9 * sq - sum * sum;
		neg = (9 * w[CENTER_IDX]) < sum;
		num = neg ? sum - 9 * w[CENTER_IDX] : 9 * w[CENTER_IDX] - sum;
		num *= g;
		// flat window: keep the mean only
		if (var9 != 0) begin
			root = int_sqrt(var9 << (2 * FRAC));
			if (root != 0)
				term = (num << (2 * FRAC)) / root;
		end
		mean_fx = (sum << FRAC) / 9;
		x = longint'(mean_fx) + (longint'(1) << (FRAC - 1));
		x = neg ? x - longint'(term) : x + longint'(term);
		if (x < 0) begin
			r.pixel_out = 8'd0;
			r.clipped = 1'b1;
		end else if ((x >>> FRAC) > 255) begin
			r.pixel_out = PIX_MAX;
			r.clipped = 1'b1;
		end else begin
			r.pixel_out = 8'(x >>> FRAC);
			r.clipped = 1'b0;
		end
		return r;
	endfunction

	function automatic window_t fill_window(int kind);
		window_t w;
		int base, spread;
		base = $urandom_range(255);
		spread = $urandom_range(12);
		for (int i = 0; i < NUM_PIX; i++) begin
			case (kind)
				0: begin
					w[i] = PIX_W'(base);
				end
				1: begin
					w[i] = PIX_W'(base + int'($urandom_range(2 * spread)) - spread);
					if (base + spread > 255 || base < spread)
						w[i] = PIX_W'(base);
				end
				2: begin
					w[i] = $urandom_range(1) ? 8'hFF : 8'h00;
				end
				default: begin
					w[i] = PIX_W'($urandom_range(255));
				end
			endcase
		end
		if (kind == 1 && $urandom_range(1))
			w[CENTER_IDX] = PIX_W'($urandom_range(255));
		return w;
	endfunction

	task automatic write_gain(logic [GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		gain_now = g;
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_window(window_t w);
		logic [IN_W-1:0] word;
		for (int i = 0; i < NUM_PIX; i++)
			word[i*PIX_W +: PIX_W] = w[i];
		while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_pixels.push_back(enhance_window(w, gain_now));
	endtask

	always @(posedge clk) begin
		m_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		enhanced_t exp_px;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected word: pixel_out %0d clipped %0d", m_tdata, m_tuser);
				err_count++;
			end else begin
				exp_px = pending_pixels.pop_front();
				if (m_tdata !== exp_px.pixel_out) begin
					$error("pixel_out expected %0d actual %0d", exp_px.pixel_out, m_tdata);
					err_count++;
				end
				if (m_tuser !== exp_px.clipped) begin
					$error("clipped expected %0d actual %0d", exp_px.clipped, m_tuser);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYC) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		row_t    rows[$];
		row_t    r;
		window_t w;
		logic [GAIN_W-1:0] gains[7];

		// directed windows; gain changes go in between rows while the pipe is empty
		r.known = 1'b1;
		r.gain = GAIN_RESET;
		r.win = '{default: 8'h00}; r.res = '{8'd0, 1'b0}; rows.push_back(r);
		r.win = '{default: 8'hFF}; r.res = '{8'd255, 1'b0}; rows.push_back(r);
		r.win = '{default: 8'h80}; r.res = '{8'd128, 1'b0}; rows.push_back(r);
		r.known = 1'b0;
		r.win = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		rows.push_back(r);
		r.win = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		rows.push_back(r);
		r.win = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFE};
		rows.push_back(r);
		r.win = '{8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h01};
		rows.push_back(r);
		r.known = 1'b1;
		r.gain = 8'd255;
		r.win = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		r.res = '{8'd255, 1'b1}; rows.push_back(r);
		r.win = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		r.res = '{8'd0, 1'b1}; rows.push_back(r);
		r.win = '{default: 8'h37}; r.res = '{8'd55, 1'b0}; rows.push_back(r);
		r.known = 1'b0;
		r.win = '{8'h10, 8'h11, 8'h10, 8'h11, 8'h10, 8'h11, 8'h10, 8'h11, 8'h10};
		rows.push_back(r);
		r.known = 1'b1;
		r.gain = 8'd0;
		r.win = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		r.res = '{8'd28, 1'b0}; rows.push_back(r);
		r.win = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		r.res = '{8'd227, 1'b0}; rows.push_back(r);
		r.known = 1'b0;
		r.win = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
		rows.push_back(r);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].gain != gain_now) begin
				s_tvalid <= 1'b0;
				drain();
				write_gain(rows[i].gain);
			end
			send_window(rows[i].win);
			if (rows[i].known) begin
				// typed value replaces the predictor's expected result
				pending_pixels.pop_back();
				pending_pixels.push_back(rows[i].res);
			end
		end

		gains = '{8'd3, 8'd255, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0};
		for (int k = 4; k < 7; k++)
			gains[k] = GAIN_W'($urandom_range(2, 254));
		for (int p = 0; p < 7; p++) begin
			s_tvalid <= 1'b0;
			drain();
			write_gain(gains[p]);
			tx_steady = (p == 2);
			rx_steady = (p == 2);
			for (int n = 0; n < 200; n++) begin
				w = fill_window($urandom_range(99) < 50 ? 3 : $urandom_range(2));
				send_window(w);
				if (p == 4 && n == 100) begin
					// hold the sender until every result is back
					s_tvalid <= 1'b0;
					while (pending_pixels.size() != 0)
						@(posedge clk);
				end
			end
		end
		s_tvalid <= 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		drain();

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
